// ===== hw/rtl/wichmann_hill_uniform_generator_top_defines.svh =====
// Assertion macros used by the checker file of the Wichmann-Hill generator.
`ifndef WICHMANN_HILL_UNIFORM_GENERATOR_TOP_DEFINES_SVH
`define WICHMANN_HILL_UNIFORM_GENERATOR_TOP_DEFINES_SVH

// Property checked on i_clk and switched off while i_rst_n is low.
`define WHU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on i_clk at every edge, reset included.
`define WHU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/whu_pkg.sv =====
// Package with the types, constants and step function of the Wichmann-Hill generator.
package whu_pkg;

    localparam int GEN_COUNT = 3;
    localparam int GEN_W     = 15;
    localparam int DATA_W    = 32;
    localparam int SPAN_W    = 33;
    localparam int FRAC48_W  = 48;
    localparam int CFG_IDX_W = 2;
    localparam int NSTAGE    = 7;

    localparam logic ACT_DRAW   = 1'b0;
    localparam logic ACT_RESEED = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_THIRD  = 2'd2;

    localparam int ST_A = 0;
    localparam int ST_B = 1;
    localparam int ST_C = 2;
    localparam int ST_D = 3;
    localparam int ST_E = 4;
    localparam int ST_F = 5;
    localparam int ST_G = 6;

    // Schrage constants: multiplier, q = m div a, r = m mod a, modulus.
    localparam logic [7:0]       MUL_FIRST  = 8'd171;
    localparam logic [7:0]       Q_FIRST    = 8'd177;
    localparam logic [5:0]       R_FIRST    = 6'd2;
    localparam logic [GEN_W-1:0] MOD_FIRST  = 15'd30269;
    localparam logic [7:0]       MUL_SECOND = 8'd172;
    localparam logic [7:0]       Q_SECOND   = 8'd176;
    localparam logic [5:0]       R_SECOND   = 6'd35;
    localparam logic [GEN_W-1:0] MOD_SECOND = 15'd30307;
    localparam logic [7:0]       MUL_THIRD  = 8'd170;
    localparam logic [7:0]       Q_THIRD    = 8'd178;
    localparam logic [5:0]       R_THIRD    = 6'd63;
    localparam logic [GEN_W-1:0] MOD_THIRD  = 15'd30323;

    // Reciprocals for the division by q: ceil(2^23 / q), exact for any 15-bit value.
    localparam int QSHIFT = 23;
    localparam logic [15:0] QREC_FIRST  =
        16'(((64'd1 << QSHIFT) + 64'(Q_FIRST) - 64'd1) / 64'(Q_FIRST));
    localparam logic [15:0] QREC_SECOND =
        16'(((64'd1 << QSHIFT) + 64'(Q_SECOND) - 64'd1) / 64'(Q_SECOND));
    localparam logic [15:0] QREC_THIRD  =
        16'(((64'd1 << QSHIFT) + 64'(Q_THIRD) - 64'd1) / 64'(Q_THIRD));

    // g * 2^48 / m is split as g * FQ + (g * FC) / m, with FQ = 2^48 div m and
    // FC = 2^48 mod m. The small quotient uses KREC = 2^32 div m and one correction.
    localparam logic [GEN_W-1:0] MODULUS [GEN_COUNT] = '{MOD_FIRST, MOD_SECOND, MOD_THIRD};
    localparam logic [33:0] FQ [GEN_COUNT] = '{
        34'((64'd1 << 48) / 64'(MOD_FIRST)),
        34'((64'd1 << 48) / 64'(MOD_SECOND)),
        34'((64'd1 << 48) / 64'(MOD_THIRD))};
    localparam logic [GEN_W-1:0] FC [GEN_COUNT] = '{
        15'((64'd1 << 48) % 64'(MOD_FIRST)),
        15'((64'd1 << 48) % 64'(MOD_SECOND)),
        15'((64'd1 << 48) % 64'(MOD_THIRD))};
    localparam logic [17:0] KREC [GEN_COUNT] = '{
        18'((64'd1 << 32) / 64'(MOD_FIRST)),
        18'((64'd1 << 32) / 64'(MOD_SECOND)),
        18'((64'd1 << 32) / 64'(MOD_THIRD))};

    typedef logic [GEN_COUNT-1:0][GEN_W-1:0] t_gen_set;
    typedef logic [NSTAGE-1:0] t_stage_en;

    typedef struct packed {
        logic                     reseed;
        logic                     bad;
        logic signed [DATA_W-1:0] lower;
        logic [SPAN_W-1:0]        span;
    } t_side;

    // One Schrage step; the result always lies in [0, m).
    function automatic logic [GEN_W-1:0] schrage_step(
        input logic [GEN_W-1:0] v,
        input logic [7:0]       mul,
        input logic [7:0]       q,
        input logic [5:0]       r,
        input logic [GEN_W-1:0] m,
        input logic [15:0]      qrec
    );
        logic [30:0]        prod;
        logic [7:0]         qt;
        logic [15:0]        qq;
        logic [7:0]         rm;
        logic signed [16:0] n;
        prod = 31'(v) * 31'(qrec);
        qt   = prod[30:23];
        qq   = 16'(qt) * 16'(q);
        rm   = 8'(16'(v) - qq);
        n    = $signed(17'(16'(rm) * 16'(mul))) - $signed(17'(14'(qt) * 14'(r)));
        if (n[16]) begin
            n = n + $signed(17'(m));
        end
        return n[GEN_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/whu_ifs.sv =====
// Valid/ready channel interfaces of the Wichmann-Hill generator.
interface whu_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic signed [whu_pkg::DATA_W-1:0] lower_bound;
    logic signed [whu_pkg::DATA_W-1:0] upper_bound;

    modport source (output valid, action, lower_bound, upper_bound, input ready);
    modport sink   (input valid, action, lower_bound, upper_bound, output ready);
endinterface

interface whu_out_if;
    logic                            valid;
    logic                            ready;
    logic [whu_pkg::DATA_W-1:0]        fraction;
    logic signed [whu_pkg::DATA_W-1:0] value;
    logic                            bad_range;

    modport source (output valid, fraction, value, bad_range, input ready);
    modport sink   (input valid, fraction, value, bad_range, output ready);
endinterface

interface whu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [whu_pkg::CFG_IDX_W-1:0]    index;
    logic [whu_pkg::GEN_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/whu_state.sv =====
// Seed registers and three congruential generators; draws step them, reseeds load them.
module whu_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    whu_cfg_if.sink           i_cfg,
    input  logic              i_accept,
    input  logic              i_action,
    output whu_pkg::t_gen_set o_gen
);
    import whu_pkg::*;

    t_gen_set r_seed;
    t_gen_set r_gen;
    t_gen_set n_seed;
    t_gen_set n_gen;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_seed = r_seed;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SEED_FIRST:  n_seed[0] = i_cfg.data;
                CFG_SEED_SECOND: n_seed[1] = i_cfg.data;
                CFG_SEED_THIRD:  n_seed[2] = i_cfg.data;
                default:         n_seed = r_seed;
            endcase
        end
    end

    always_comb begin
        n_gen = r_gen;
        if (i_accept) begin
            if (i_action == ACT_RESEED) begin
                n_gen = r_seed;
            end else begin
                n_gen[0] = schrage_step(r_gen[0], MUL_FIRST, Q_FIRST, R_FIRST,
                                        MOD_FIRST, QREC_FIRST);
                n_gen[1] = schrage_step(r_gen[1], MUL_SECOND, Q_SECOND, R_SECOND,
                                        MOD_SECOND, QREC_SECOND);
                n_gen[2] = schrage_step(r_gen[2], MUL_THIRD, Q_THIRD, R_THIRD,
                                        MOD_THIRD, QREC_THIRD);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= {GEN_COUNT{15'd1}};
            r_gen  <= {GEN_COUNT{15'd1}};
        end else begin
            r_seed <= n_seed;
            r_gen  <= n_gen;
        end
    end

    assign o_gen = r_gen;

endmodule

// ===== hw/rtl/whu_frac.sv =====
// Fixed-point quotient pipeline: scales the three generators and sums them modulo one.
module whu_frac (
    input  logic                      i_clk,
    input  whu_pkg::t_stage_en        i_en,
    input  whu_pkg::t_gen_set         i_gen,
    output logic [whu_pkg::DATA_W-1:0] o_frac
);
    import whu_pkg::*;

    logic [29:0]         r_p    [GEN_COUNT];
    logic [FRAC48_W-1:0] r_gf   [GEN_COUNT];
    logic [15:0]         r_qa   [GEN_COUNT];
    logic [29:0]         r_p_c  [GEN_COUNT];
    logic [FRAC48_W-1:0] r_gf_c [GEN_COUNT];
    logic [FRAC48_W-1:0] r_q48  [GEN_COUNT];
    logic [DATA_W-1:0]   r_frac;

    logic [47:0]         n_qprod [GEN_COUNT];
    logic [29:0]         n_rem   [GEN_COUNT];
    logic [FRAC48_W-1:0] n_q48   [GEN_COUNT];
    logic [FRAC48_W-1:0] n_sum;

    always_comb begin
        for (int i = 0; i < GEN_COUNT; i++) begin
            n_qprod[i] = 48'(r_p[i]) * 48'(KREC[i]);
            n_rem[i]   = r_p_c[i] - 30'(31'(r_qa[i]) * 31'(MODULUS[i]));
            n_q48[i]   = r_gf_c[i] + 48'(r_qa[i])
                       + 48'(n_rem[i] >= 30'(MODULUS[i]));
        end
        n_sum = r_q48[0] + r_q48[1] + r_q48[2];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < GEN_COUNT; i++) begin
            if (i_en[ST_B]) begin
                r_p[i]  <= 30'(i_gen[i]) * 30'(FC[i]);
                r_gf[i] <= 48'(49'(i_gen[i]) * 49'(FQ[i]));
            end
            if (i_en[ST_C]) begin
                r_qa[i]   <= n_qprod[i][47:32];
                r_p_c[i]  <= r_p[i];
                r_gf_c[i] <= r_gf[i];
            end
            if (i_en[ST_D]) begin
                r_q48[i] <= n_q48[i];
            end
        end
        if (i_en[ST_E]) begin
            r_frac <= n_sum[FRAC48_W-1:FRAC48_W-DATA_W];
        end
    end

    assign o_frac = r_frac;

endmodule

// ===== hw/rtl/whu_scale.sv =====
// Maps the fraction onto the requested integer range and holds the result register.
module whu_scale (
    input  logic                             i_clk,
    input  whu_pkg::t_stage_en               i_en,
    input  logic [whu_pkg::DATA_W-1:0]        i_frac,
    input  whu_pkg::t_side                   i_side,
    output logic [whu_pkg::DATA_W-1:0]        o_fraction,
    output logic signed [whu_pkg::DATA_W-1:0] o_value,
    output logic                             o_bad_range
);
    import whu_pkg::*;

    logic [2*DATA_W-1:0]      r_prod;
    logic [DATA_W-1:0]        r_f_frac;
    t_side                    r_f_side;
    logic [DATA_W-1:0]        r_fraction;
    logic signed [DATA_W-1:0] r_value;
    logic                     r_bad_range;

    logic [DATA_W-1:0]        n_off;
    logic [DATA_W-1:0]        n_fraction;
    logic signed [DATA_W-1:0] n_value;
    logic                     n_bad_range;

    always_comb begin
        // A span of the full 2^32 has zero low bits, so its offset is the fraction itself.
        n_off = r_prod[2*DATA_W-1:DATA_W]
              + (r_f_side.span[SPAN_W-1] ? r_f_frac : '0);
        if (r_f_side.reseed) begin
            n_fraction  = '0;
            n_value     = '0;
            n_bad_range = 1'b0;
        end else if (r_f_side.bad) begin
            n_fraction  = r_f_frac;
            n_value     = r_f_side.lower;
            n_bad_range = 1'b1;
        end else begin
            n_fraction  = r_f_frac;
            n_value     = r_f_side.lower + $signed(n_off);
            n_bad_range = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_F]) begin
            r_prod   <= 64'(i_frac) * 64'(i_side.span[DATA_W-1:0]);
            r_f_frac <= i_frac;
            r_f_side <= i_side;
        end
        if (i_en[ST_G]) begin
            r_fraction  <= n_fraction;
            r_value     <= n_value;
            r_bad_range <= n_bad_range;
        end
    end

    assign o_fraction  = r_fraction;
    assign o_value     = r_value;
    assign o_bad_range = r_bad_range;

endmodule

// ===== hw/rtl/wichmann_hill_uniform_generator_top.sv =====
// Top level of the Wichmann-Hill uniform generator with its pipeline control.
// Channels: i_in takes items (action draw or reseed, lower and upper bound), o_out
// gives one result per item (fraction, value, bad_range) in order, and i_cfg writes
// the three seed registers by index; it is always ready and takes effect on the
// next reseed item.
// A draw advances the three generators in the cycle of its transfer; the item then
// fills seven register stages, the input register first, and o_out.valid rises when
// it reaches the result register. One item is taken in every cycle while the output
// is not stalled: the quotient and scaling pipeline sets the latency, the generator
// step, computed combinationally, sets the rate.
// When the receiver stalls, the result register holds its value and each stage keeps
// accepting while an empty stage lies ahead of it, so up to seven items are held
// before i_in.ready falls.
// A reseed result carries zero fraction, value and flag.
// Reset clears every stage valid bit and sets the seeds and generators to one.
module wichmann_hill_uniform_generator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    whu_in_if.sink     i_in,
    whu_out_if.source  o_out,
    whu_cfg_if.sink    i_cfg
);
    import whu_pkg::*;

    t_stage_en                r_vld;
    t_stage_en                n_en;
    logic                     n_accept;
    t_gen_set                 n_gen;
    logic                     r_a_reseed;
    logic signed [DATA_W-1:0] r_a_lower;
    logic signed [DATA_W-1:0] r_a_upper;
    t_side                    r_side [ST_E];
    t_side                    n_side_b;
    logic signed [SPAN_W-1:0] n_diff;
    logic [DATA_W-1:0]        n_frac;

    always_comb begin
        n_en[ST_G] = !r_vld[ST_G] || o_out.ready;
        for (int k = ST_F; k >= ST_A; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign i_in.ready = n_en[ST_A];
    assign n_accept   = i_in.valid && n_en[ST_A];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[ST_A]) begin
                r_vld[ST_A] <= i_in.valid;
            end
            for (int k = ST_B; k <= ST_G; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n_diff          = SPAN_W'(r_a_upper) - SPAN_W'(r_a_lower);
        n_side_b.reseed = (r_a_reseed == ACT_RESEED);
        n_side_b.bad    = (r_a_upper < r_a_lower);
        n_side_b.lower  = r_a_lower;
        n_side_b.span   = n_diff + SPAN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[ST_A]) begin
            r_a_reseed <= i_in.action;
            r_a_lower  <= i_in.lower_bound;
            r_a_upper  <= i_in.upper_bound;
        end
        if (n_en[ST_B]) begin
            r_side[0] <= n_side_b;
        end
        for (int k = 1; k < ST_E; k++) begin
            if (n_en[k+1]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    whu_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_accept (n_accept),
        .i_action (i_in.action),
        .o_gen    (n_gen)
    );

    whu_frac u_frac (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_gen  (n_gen),
        .o_frac (n_frac)
    );

    whu_scale u_scale (
        .i_clk       (i_clk),
        .i_en        (n_en),
        .i_frac      (n_frac),
        .i_side      (r_side[ST_E-1]),
        .o_fraction  (o_out.fraction),
        .o_value     (o_out.value),
        .o_bad_range (o_out.bad_range)
    );

    assign o_out.valid = r_vld[ST_G];

endmodule

// ===== hw/rtl/whu_checker.sv =====
// Port-level checker for the Wichmann-Hill generator and its bind to the top level.
`include "wichmann_hill_uniform_generator_top_defines.svh"

module whu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [whu_pkg::DATA_W-1:0]        i_fraction,
    input logic signed [whu_pkg::DATA_W-1:0] i_value,
    input logic                             i_bad_range
);

    // A stalled result stays offered and unchanged.
    `WHU_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fraction) && $stable(i_value) && $stable(i_bad_range), "stalled result changed")

    // Reset empties the pipeline.
    `WHU_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_out_valid, "result offered after reset")

    // With the receiver ready throughout, a transfer in is offered at the output once it reaches the result register.
    `WHU_ASSERT(a_latency, (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid, "result missing after pipeline latency")

endmodule

bind wichmann_hill_uniform_generator_top whu_checker u_whu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_fraction  (o_out.fraction),
    .i_value     (o_out.value),
    .i_bad_range (o_out.bad_range)
);
